[sv/binary_map_binomial_blur_5x5_macros.svh]
// Assertion macros for the blur block's top-level RTL file.
`ifndef BINARY_MAP_BINOMIAL_BLUR_5X5_MACROS_SVH
`define BINARY_MAP_BINOMIAL_BLUR_5X5_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define BMB5_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("blur block check failed");

// Next-cycle implication, disabled while reset is high.
`define BMB5_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("blur block check failed");

`else

`define BMB5_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define BMB5_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[sv/bmb5_pkg.sv]
// Package with the shared constants and kernel helpers of the blur block.
package bmb5_pkg;

   localparam int DEFAULT_MAP_WIDTH  = 160;
   localparam int DEFAULT_MAP_HEIGHT = 120;

   localparam int COORD_W = 8;
   localparam int SCALE_W = 2;
   localparam int GREY_W  = 8;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 2'd2;

   // Kernel geometry: five taps per axis, centred two taps in.
   localparam logic [2:0] TAP_LAST      = 3'd4;
   localparam logic [8:0] KERNEL_RADIUS = 9'd2;

   localparam logic OP_MARK  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Binomial weights 1-2-4-2-1 as powers of two.
   function automatic logic [1:0] tap_exp(input logic [2:0] tap);
      logic [1:0] e;
      case (tap)
         3'd1, 3'd3: e = 2'd1;
         3'd2:       e = 2'd2;
         default:    e = 2'd0;
      endcase
      return e;
   endfunction

endpackage

[sv/bmb5_ram.sv]
// Generic single-port RAM with registered read data.
module bmb5_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

endmodule

[sv/binary_map_binomial_blur_5x5.sv]
// Top level of the binomial 5x5 blur over a one-bit pixel map.
//
// The block holds a one-bit map of a MAP_WIDTH by MAP_HEIGHT screen in a single-port
// RAM, one pixel per entry. A request word with tuser low marks the pixel at (x, y);
// with tuser high it asks for the grey level at (x, y): the sum over the 5x5
// neighbourhood of the binomial weights 1-2-4-2-1 by 1-2-4-2-1, times the scale
// register, for every set neighbour, neighbours off the screen counting as zero and
// the result saturating at 255. Every request gives exactly one response word; a
// coordinate off the screen returns bad_coord set and grey level zero and leaves the
// map untouched. After reset the map is swept clear one entry per cycle; no request is
// taken meanwhile, though the scale register may be written. Timing is set by the one
// RAM port: a mark or an off-screen request goes from acceptance straight to hand-over,
// while a query is accepted, reads its 25 neighbours in turn, adds the last read in a
// drain state and hands over; hand-over waits while the previous word is not yet taken.
// The next request is taken as soon as the block is back to idle, even while the
// previous response word still waits in the output register.
module binary_map_binomial_blur_5x5 #(
   parameter int MAP_WIDTH  = bmb5_pkg::DEFAULT_MAP_WIDTH,
   parameter int MAP_HEIGHT = bmb5_pkg::DEFAULT_MAP_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] x_coord, [15:8] y_coord
   input  logic        req_tuser,   // [0] opcode
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] grey_level
   output logic        rsp_tuser,   // [0] bad_coord
   // Scale register.
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);

`include "binary_map_binomial_blur_5x5_macros.svh"

   localparam int Depth  = MAP_WIDTH * MAP_HEIGHT;
   localparam int AddrW  = $clog2(Depth);
   localparam int CW     = bmb5_pkg::COORD_W;

   // Sequencer states.
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_QUERY = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]                      state_ff, state_in;
   logic [AddrW-1:0]                clr_ff, clr_in;
   logic [bmb5_pkg::SCALE_W-1:0]    scale_ff, scale_in;
   logic [CW-1:0]                   cx_ff, cx_in, cy_ff, cy_in;
   logic [2:0]                      dx_ff, dx_in, dy_ff, dy_in;
   logic [bmb5_pkg::GREY_W-1:0]     acc_ff, acc_in;
   logic                            bad_ff, bad_in;
   logic                            pipe_vld_ff, pipe_vld_in;
   logic                            pipe_ok_ff, pipe_ok_in;
   logic [2:0]                      pipe_exp_ff, pipe_exp_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bmb5_pkg::GREY_W-1:0]     rsp_grey_ff, rsp_grey_in;
   logic                            rsp_bad_ff, rsp_bad_in;

   logic [CW-1:0]    req_x, req_y;
   logic             req_fire, req_off;
   logic [8:0]       col_sum, row_sum, col_off, row_off;
   logic             nb_ok;
   logic [CW-1:0]    row_sel, col_sel;
   logic [AddrW-1:0] addr_calc;
   logic             ram_we, ram_wdata, ram_rdata;
   logic [AddrW-1:0] ram_addr;
   logic [5:0]       weight;
   logic [8:0]       acc_sum;
   logic             rsp_load;

   assign req_x    = req_tdata[7:0];
   assign req_y    = req_tdata[15:8];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign req_off  = ({1'b0, req_x} >= 9'(MAP_WIDTH)) || ({1'b0, req_y} >= 9'(MAP_HEIGHT));

   // Neighbour under the current tap, shifted by the kernel radius.
   assign col_sum = {1'b0, cx_ff} + {6'd0, dx_ff};
   assign row_sum = {1'b0, cy_ff} + {6'd0, dy_ff};
   assign col_off = col_sum - bmb5_pkg::KERNEL_RADIUS;
   assign row_off = row_sum - bmb5_pkg::KERNEL_RADIUS;
   assign nb_ok   = (col_sum >= bmb5_pkg::KERNEL_RADIUS) && (col_off < 9'(MAP_WIDTH))
                 && (row_sum >= bmb5_pkg::KERNEL_RADIUS) && (row_off < 9'(MAP_HEIGHT));

   // The one address unit, shared by marks and neighbour reads.
   assign row_sel   = (state_ff == S_IDLE) ? req_y : row_off[7:0];
   assign col_sel   = (state_ff == S_IDLE) ? req_x : col_off[7:0];
   assign addr_calc = AddrW'(AddrW'(row_sel) * AddrW'(MAP_WIDTH)) + AddrW'(col_sel);

   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = 1'b1;
      ram_addr  = addr_calc;
      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = 1'b0;
            ram_addr  = clr_ff;
         end
         S_IDLE: begin
            ram_we = req_fire && (req_tuser == bmb5_pkg::OP_MARK) && !req_off;
         end
         S_QUERY: begin
            // Off-screen taps read a harmless in-range entry and are masked later.
            ram_addr = nb_ok ? addr_calc : '0;
         end
         default: begin
            ram_addr = addr_calc;
         end
      endcase
   end

   bmb5_ram #(
      .WIDTH (1),
      .DEPTH (Depth)
   ) u_map (
      .clock    (clock),
      .we       (ram_we),
      .addr     (ram_addr),
      .wdata    (ram_wdata),
      .rdata_ff (ram_rdata)
   );

   // Weight of the tap whose read data arrives this cycle, and the saturating sum.
   assign weight  = 6'(scale_ff) << pipe_exp_ff;
   assign acc_sum = {1'b0, acc_ff} + {3'd0, weight};

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      acc_in       = acc_ff;
      bad_in       = bad_ff;
      pipe_vld_in  = 1'b0;
      pipe_ok_in   = nb_ok;
      pipe_exp_in  = {1'b0, bmb5_pkg::tap_exp(dx_ff)} + {1'b0, bmb5_pkg::tap_exp(dy_ff)};
      scale_in     = csr_wr_en ? csr_wr_data : scale_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_grey_in  = rsp_grey_ff;
      rsp_bad_in   = rsp_bad_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (pipe_vld_ff && pipe_ok_ff && ram_rdata) begin
         acc_in = acc_sum[8] ? '1 : acc_sum[7:0];
      end

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AddrW'(Depth - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cx_in  = req_x;
               cy_in  = req_y;
               dx_in  = '0;
               dy_in  = '0;
               acc_in = '0;
               bad_in = req_off;
               if (!req_off && (req_tuser == bmb5_pkg::OP_QUERY)) begin
                  state_in = S_QUERY;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_QUERY: begin
            pipe_vld_in = 1'b1;
            if (dx_ff == bmb5_pkg::TAP_LAST) begin
               dx_in = '0;
               dy_in = dy_ff + 1'b1;
               if (dy_ff == bmb5_pkg::TAP_LAST) begin
                  state_in = S_DRAIN;
               end
            end else begin
               dx_in = dx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_grey_in  = acc_ff;
               rsp_bad_in   = bad_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         scale_ff     <= bmb5_pkg::SCALE_RESET;
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         scale_ff     <= scale_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      acc_ff      <= acc_in;
      bad_ff      <= bad_in;
      pipe_ok_ff  <= pipe_ok_in;
      pipe_exp_ff <= pipe_exp_in;
      rsp_grey_ff <= rsp_grey_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_grey_ff;
   assign rsp_tuser  = rsp_bad_ff;

   // A valid on-screen query starts its neighbour sweep at the first tap.
   `BMB5_ASSERT_NEXT(a_query_start, clock, reset,
      req_fire && (req_tuser == bmb5_pkg::OP_QUERY) && !req_off,
      state_ff == S_QUERY && dx_ff == '0 && dy_ff == '0)

   // The map is only written by the clearing sweep or by an accepted mark.
   `BMB5_ASSERT_NOW(a_write_source, clock, reset, ram_we,
      state_ff == S_CLEAR || (req_fire && !req_off))

   // Read data is only summed while a sweep is running or draining.
   `BMB5_ASSERT_NOW(a_pipe_in_sweep, clock, reset, pipe_vld_ff,
      state_ff == S_QUERY || state_ff == S_DRAIN)

   // A response word only appears after the hand-over state.
   `BMB5_ASSERT_NOW(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == S_DONE)

endmodule

[sim/tb_binary_map_binomial_blur_5x5.sv]
// Self-checking testbench for the binomial 5x5 blur over a one-bit pixel map.
module tb_binary_map_binomial_blur_5x5;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAP_W       = bmb5_pkg::DEFAULT_MAP_WIDTH;
   localparam int MAP_H       = bmb5_pkg::DEFAULT_MAP_HEIGHT;
   localparam int CYCLE_LIMIT = 500_000;
   localparam int SETTLE      = 40;

   // One request word as the sender sees it, and one response word as expected.
   typedef struct packed {
      logic                         op;
      logic [bmb5_pkg::COORD_W-1:0] x;
      logic [bmb5_pkg::COORD_W-1:0] y;
   } blur_req_type;

   typedef struct packed {
      logic [bmb5_pkg::GREY_W-1:0] grey;
      logic                        bad;
   } blur_rsp_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;   // [7:0] x_coord, [15:8] y_coord
   logic        req_tuser   = 1'b0; // [0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;          // [7:0] grey_level
   logic        rsp_tuser;          // [0] bad_coord
   logic        csr_wr_en   = 1'b0;
   logic [1:0]  csr_wr_data = '0;

   // Words waiting to be sent, and the responses that the words already taken must give.
   blur_req_type pending_words[$];
   blur_rsp_type expected_results[$];

   // The testbench's own copy of the pixel map and of the scale register.
   bit                           pixel_map [0:MAP_H-1][0:MAP_W-1];
   logic [bmb5_pkg::SCALE_W-1:0] scale_now;

   int           fail_count  = 0;
   int           cycle_count = 0;
   int           gap_left    = 0;
   int           stall_left  = 0;
   int           req_calm    = 0;
   int           rsp_calm    = 0;
   blur_req_type word_on_bus;

   binary_map_binomial_blur_5x5 dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 0;
   end

   // The run is cut short here if the block stops answering.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   // Each side idles between words. Most of the time the wait is drawn at random, but
   // now and then a calm stretch begins in which that side never idles.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   // Grey level at (cx, cy): every set neighbour adds its binomial weight times the
   // scale. The weight along one axis is 4, 2 or 1 for an offset of 0, 1 or 2, so it
   // is simply 4 shifted right by the distance from the centre.
   function automatic logic [bmb5_pkg::GREY_W-1:0] blur_grey(input int cx, input int cy);
      int sum;
      int px;
      int py;
      sum = 0;
      for (int dy = -2; dy <= 2; dy++) begin
         for (int dx = -2; dx <= 2; dx++) begin
            px = cx + dx;
            py = cy + dy;
            if (px >= 0 && px < MAP_W && py >= 0 && py < MAP_H && pixel_map[py][px])
               sum += (4 >> (dx < 0 ? -dx : dx)) * (4 >> (dy < 0 ? -dy : dy))
                      * int'(scale_now);
         end
      end
      // With the scale at 3 a dense neighbourhood exceeds the 8-bit range and clamps.
      return (sum > 255) ? 8'd255 : sum[bmb5_pkg::GREY_W-1:0];
   endfunction

   // Applies one accepted request word to the map copy and returns its response.
   function automatic blur_rsp_type apply_request(input blur_req_type w);
      blur_rsp_type r;
      r.grey = '0;
      r.bad  = 1'b0;
      if (w.x >= MAP_W || w.y >= MAP_H)
         r.bad = 1'b1;      // off the screen: ignored, whatever the operation
      else if (w.op == bmb5_pkg::OP_MARK)
         pixel_map[w.y][w.x] = 1'b1;
      else
         r.grey = blur_grey(w.x, w.y);
      return r;
   endfunction

   // Sender. A word is taken at an edge where tvalid and tready are both high; the
   // expectation is worked out right there, so the map copy follows the block's order.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_request(word_on_bus));
            gap_left = draw_wait(req_calm);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               word_on_bus = pending_words.pop_front();
               req_tdata  <= {word_on_bus.y, word_on_bus.x};
               req_tuser  <= word_on_bus.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver. Each response word is held against the oldest expectation, field by field.
   always @(posedge clock) begin
      blur_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("response grey %0d bad %b with none expected",
                                         rsp_tdata, rsp_tuser));
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata !== want.grey)
                  report_mismatch($sformatf("grey_level %0d, expected %0d",
                                            rsp_tdata, want.grey));
               if (rsp_tuser !== want.bad)
                  report_mismatch($sformatf("bad_coord %b, expected %b",
                                            rsp_tuser, want.bad));
            end
            stall_left = draw_wait(rsp_calm);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Coordinates arrive as integers so that offsets past an edge simply wrap into
   // the off-screen codes, which is just what the clusters near an edge want.
   function automatic void queue_word(input logic op, input int x, input int y);
      blur_req_type w;
      w.op = op;
      w.x  = x[bmb5_pkg::COORD_W-1:0];
      w.y  = y[bmb5_pkg::COORD_W-1:0];
      pending_words.push_back(w);
   endfunction

   // Returns once nothing is left to send and every response has come back. Sampled
   // on the falling edge so that the sender's and receiver's updates have settled.
   task automatic wait_until_drained();
      do
         @(negedge clock);
      while (pending_words.size() != 0 || req_tvalid || expected_results.size() != 0);
   endtask

   // No words are in flight whenever this is called, so the write cannot race a word.
   task automatic write_scale(input logic [bmb5_pkg::SCALE_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      scale_now = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Random words, mostly in clusters: a handful of marks around a centre followed by
   // queries next to it, so that the grey levels are seldom zero. Now and then the
   // whole 5x5 patch is filled, which drives the sum to its top (and beyond at scale 3).
   // Centres are often put hard against an edge so that clipping is exercised; the
   // rest is single queries and noise over the full coordinate range.
   task automatic random_phase(input int n_words);
      int made;
      int cx;
      int cy;
      int marks;
      int probes;
      int pick;
      made = 0;
      while (made < n_words) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            if ($urandom_range(0, 3) == 0) begin
               cx = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(156, 159);
               cy = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(116, 119);
            end else begin
               cx = $urandom_range(0, MAP_W - 1);
               cy = $urandom_range(0, MAP_H - 1);
            end
            marks = ($urandom_range(0, 7) == 0) ? 25 : $urandom_range(1, 10);
            for (int k = 0; k < marks; k++) begin
               if (marks == 25)
                  queue_word(bmb5_pkg::OP_MARK, cx + k % 5 - 2, cy + k / 5 - 2);
               else
                  queue_word(bmb5_pkg::OP_MARK, cx + int'($urandom_range(0, 4)) - 2,
                             cy + int'($urandom_range(0, 4)) - 2);
            end
            probes = $urandom_range(1, 4);
            for (int k = 0; k < probes; k++)
               queue_word(bmb5_pkg::OP_QUERY, cx + int'($urandom_range(0, 4)) - 2,
                          cy + int'($urandom_range(0, 4)) - 2);
            made += marks + probes;
         end else if (pick < 85) begin
            queue_word(bmb5_pkg::OP_QUERY, $urandom_range(0, MAP_W - 1),
                       $urandom_range(0, MAP_H - 1));
            made++;
         end else begin
            queue_word(logic'($urandom_range(0, 1)), $urandom_range(0, 255),
                       $urandom_range(0, 255));
            made++;
         end
      end
   endtask

   initial begin
      scale_now = bmb5_pkg::SCALE_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The block sweeps its map clear after reset; the register may be written
      // meanwhile, and the first word simply waits for tready.
      write_scale(2'd2);

      // Directed words: an empty-map query, the four corners, a pixel two in from a
      // corner so that clipped and unclipped weights meet, off-screen marks that must
      // leave the map alone, and off-screen queries on either axis.
      queue_word(bmb5_pkg::OP_QUERY, 0, 0);
      queue_word(bmb5_pkg::OP_MARK, 0, 0);
      queue_word(bmb5_pkg::OP_MARK, MAP_W - 1, 0);
      queue_word(bmb5_pkg::OP_MARK, 0, MAP_H - 1);
      queue_word(bmb5_pkg::OP_MARK, MAP_W - 1, MAP_H - 1);
      queue_word(bmb5_pkg::OP_MARK, 2, 2);
      queue_word(bmb5_pkg::OP_QUERY, 0, 0);
      queue_word(bmb5_pkg::OP_QUERY, 1, 1);
      queue_word(bmb5_pkg::OP_QUERY, 2, 2);
      queue_word(bmb5_pkg::OP_QUERY, MAP_W - 1, 0);
      queue_word(bmb5_pkg::OP_QUERY, 0, MAP_H - 1);
      queue_word(bmb5_pkg::OP_QUERY, MAP_W - 1, MAP_H - 1);
      queue_word(bmb5_pkg::OP_QUERY, MAP_W - 2, MAP_H - 2);
      queue_word(bmb5_pkg::OP_QUERY, MAP_W - 3, MAP_H - 3);
      queue_word(bmb5_pkg::OP_MARK, MAP_W, 0);
      queue_word(bmb5_pkg::OP_MARK, 0, MAP_H);
      queue_word(bmb5_pkg::OP_MARK, 255, 255);
      queue_word(bmb5_pkg::OP_QUERY, MAP_W - 1, 1);
      queue_word(bmb5_pkg::OP_QUERY, 1, MAP_H - 1);
      queue_word(bmb5_pkg::OP_QUERY, MAP_W, MAP_H - 1);
      queue_word(bmb5_pkg::OP_QUERY, 0, 255);
      queue_word(bmb5_pkg::OP_QUERY, 255, 0);
      queue_word(bmb5_pkg::OP_QUERY, MAP_W / 2, MAP_H / 2);
      wait_until_drained();

      // Random phases under several scales, both extremes among them. The test
      // holds off before each write until every response has come back.
      write_scale(2'd3);
      random_phase(100);
      wait_until_drained();
      write_scale(2'd0);
      random_phase(100);
      wait_until_drained();
      write_scale(2'd1);
      random_phase(100);
      wait_until_drained();
      write_scale(2'd2);
      random_phase(100);
      wait_until_drained();
      write_scale(2'd3);
      random_phase(100);
      wait_until_drained();

      // A little longer than the slowest query, so a stray extra word is caught.
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/bmb5_pkg.sv
sv/bmb5_ram.sv
sv/binary_map_binomial_blur_5x5.sv
sim/tb_binary_map_binomial_blur_5x5.sv
